>>> src/rba_pkg.sv
// Shared widths, codes and defaults for the reference-counted block allocator.
package rba_pkg;

  // Default sizing of the block store.
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int COUNT_BITS_DEF = 16;

  // Port field widths.
  localparam int MODE_W    = 3;
  localparam int ID_W      = 10;
  localparam int CNT_OUT_W = 16;
  localparam int STATUS_W  = 3;
  localparam int FREE_W    = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  // Bitmap memory word layout.
  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = 5;

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEC   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY = 3'd4;
  localparam logic [MODE_W-1:0] MODE_COW   = 3'd5;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_SHARED    = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NO_FREE   = 3'd2;
  localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOT_ALLOC = 3'd4;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 2'd1;
  localparam logic [CFG_W-1:0]     BLOCK_TOTAL_RST = 11'd1024;
  localparam logic [CFG_W-1:0]     DATA_START_RST  = 11'd1;

endpackage

>>> src/refcounted_block_allocator.sv
// Each item steps through the scan, execute, new-block count write (only when a block is taken)
// and done states; req_stall holds off the next request until the response is loaded. The bitmap
// scan reads one 32-bit map word per cycle to find the first free block and count the used ones.
// Reset: a clearing pass writes ceil(NUM_BLOCKS/32) map words, one per cycle, while req_stall
// stays high; configuration writes are taken during it. Count memory needs no clearing.
module refcounted_block_allocator #(
  parameter int NUM_BLOCKS = rba_pkg::NUM_BLOCKS_DEF,
  parameter int COUNT_BITS = rba_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // Request channel.
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic [rba_pkg::MODE_W-1:0]     mode,
  input  logic [rba_pkg::ID_W-1:0]       block_id,
  // Response channel.
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output logic [rba_pkg::ID_W-1:0]       block_out,
  output logic [rba_pkg::CNT_OUT_W-1:0]  ref_count,
  output logic [rba_pkg::STATUS_W-1:0]   status,
  output logic [rba_pkg::FREE_W-1:0]     free_count,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rba_pkg::CFG_W-1:0]      cfg_data
);

  localparam int WB     = rba_pkg::WORD_BITS;
  localparam int WS     = rba_pkg::WORD_SH;
  localparam int NWORDS = (NUM_BLOCKS + WB - 1) / WB;
  localparam int WIW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int IDW    = $clog2(NUM_BLOCKS);
  localparam int LW     = $clog2(NUM_BLOCKS + 1);
  localparam int BW     = (rba_pkg::CFG_W > LW) ? rba_pkg::CFG_W : LW;
  localparam int HW     = BW - WS;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_EXEC = 3'd3;
  localparam logic [2:0] ST_WNEW = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]                    state;
  logic [rba_pkg::CFG_W-1:0]     block_total;
  logic [rba_pkg::CFG_W-1:0]     data_start;
  logic [rba_pkg::MODE_W-1:0]    mode_q;
  logic [rba_pkg::ID_W-1:0]      blk;
  logic [WIW:0]                  rd_word;
  logic                          pv;
  logic [WIW-1:0]                pw;
  logic                          found;
  logic [WIW-1:0]                found_w;
  logic [WS-1:0]                 found_b;
  logic [WB-1:0]                 found_data;
  logic [WB-1:0]                 tgt_data;
  logic [BW-1:0]                 alloc_cnt;

  // Memories and their registered read data.
  logic [WB-1:0]                 bm_mem [NWORDS];
  logic [WB-1:0]                 bm_q;
  logic [COUNT_BITS-1:0]         sh_mem [NUM_BLOCKS];
  logic [COUNT_BITS-1:0]         share_q;

  logic                          accept;
  logic                          out_load;
  logic                          bm_rd;
  logic                          bm_wr;
  logic [WIW-1:0]                bm_addr;
  logic [WB-1:0]                 bm_data;
  logic                          sh_wr;
  logic [IDW-1:0]                sh_addr;
  logic [COUNT_BITS-1:0]         sh_data;

  logic [BW-1:0]                 bt_w;
  logic [BW-1:0]                 lim_w;
  logic [BW-1:0]                 ds_w;
  logic [BW-1:0]                 range_size;
  logic [BW-1:0]                 b_w;
  logic                          b_in;
  logic [WS-1:0]                 b_bit;
  logic                          tgt_alloc;
  logic [BW-1:0]                 got_w;
  logic [COUNT_BITS-1:0]         eff;

  logic [WB-1:0]                 scan_mask;
  logic [WB-1:0]                 scan_free;
  logic [WS:0]                   scan_pop;
  logic [WS-1:0]                 scan_low;

  logic [BW-1:0]                 r_bout;
  logic [COUNT_BITS-1:0]         r_cnt;
  logic [rba_pkg::STATUS_W-1:0]  r_st;
  logic                          bm_we;
  logic [WIW-1:0]                bm_wa;
  logic [WB-1:0]                 bm_wd;
  logic                          sh_we_b;
  logic [COUNT_BITS-1:0]         sh_wd_b;
  logic                          new_we;
  logic                          free_up;
  logic                          free_dn;
  logic [BW-1:0]                 r_free;

  assign cfg_ready = !rst;
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  // Data range limits and the addressed block.
  assign bt_w       = BW'(block_total);
  assign lim_w      = (bt_w < BW'(NUM_BLOCKS)) ? bt_w : BW'(NUM_BLOCKS);
  assign ds_w       = BW'(data_start);
  assign range_size = (ds_w < lim_w) ? (lim_w - ds_w) : '0;
  assign b_w        = BW'(blk);
  assign b_in       = (ds_w <= b_w) && (b_w < lim_w);
  assign b_bit      = blk[WS-1:0];
  assign tgt_alloc  = tgt_data[b_bit];
  assign got_w      = BW'({found_w, found_b});
  assign eff        = (share_q != '0) ? share_q : COUNT_BITS'(1);

  // Per-word scan: range mask, used-bit count and lowest free bit.
  always_comb begin
    logic [HW-1:0] pwx;
    logic [WB-1:0] lo_mask;
    logic [WB-1:0] hi_mask;
    pwx = HW'(pw);
    if (pwx > ds_w[BW-1:WS]) begin
      lo_mask = '1;
    end else if (pwx == ds_w[BW-1:WS]) begin
      lo_mask = {WB{1'b1}} << ds_w[WS-1:0];
    end else begin
      lo_mask = '0;
    end
    if (pwx < lim_w[BW-1:WS]) begin
      hi_mask = '1;
    end else if (pwx == lim_w[BW-1:WS]) begin
      hi_mask = ~({WB{1'b1}} << lim_w[WS-1:0]);
    end else begin
      hi_mask = '0;
    end
    scan_mask = lo_mask & hi_mask;
    scan_free = ~bm_q & scan_mask;
    scan_pop  = '0;
    for (int i = 0; i < WB; i++) begin
      scan_pop = scan_pop + (WS + 1)'(bm_q[i] & scan_mask[i]);
    end
    scan_low = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (scan_free[i]) begin
        scan_low = WS'(i);
      end
    end
  end

  // Operation decode: result fields and the writes that the item causes.
  always_comb begin
    logic [COUNT_BITS-1:0] nv;
    nv      = '0;
    r_bout  = b_w;
    r_cnt   = '0;
    r_st    = rba_pkg::STS_OK;
    bm_we   = 1'b0;
    bm_wa   = WIW'(b_w[BW-1:WS]);
    bm_wd   = tgt_data & ~(WB'(1) << b_bit);
    sh_we_b = 1'b0;
    sh_wd_b = share_q;
    new_we  = 1'b0;
    free_up = 1'b0;
    free_dn = 1'b0;
    priority if (mode_q == rba_pkg::MODE_ALLOC) begin
      if (found) begin
        r_bout  = got_w;
        r_cnt   = COUNT_BITS'(1);
        bm_we   = 1'b1;
        bm_wa   = found_w;
        bm_wd   = found_data | (WB'(1) << found_b);
        new_we  = 1'b1;
        free_dn = 1'b1;
      end else begin
        r_bout = '0;
        r_st   = rba_pkg::STS_NO_FREE;
      end
    end else if (mode_q > rba_pkg::MODE_COW) begin
      r_bout = '0;
      r_st   = rba_pkg::STS_RANGE;
    end else if (!b_in) begin
      r_st = rba_pkg::STS_RANGE;
    end else if (!tgt_alloc) begin
      r_st = rba_pkg::STS_NOT_ALLOC;
    end else begin
      unique case (mode_q)
        rba_pkg::MODE_FREE: begin
          sh_we_b = 1'b1;
          if (eff > COUNT_BITS'(1)) begin
            nv      = eff - COUNT_BITS'(1);
            sh_wd_b = nv;
            r_cnt   = nv;
            r_st    = rba_pkg::STS_SHARED;
          end else begin
            sh_wd_b = '0;
            bm_we   = 1'b1;
            free_up = 1'b1;
          end
        end
        rba_pkg::MODE_INC: begin
          nv      = (share_q != {COUNT_BITS{1'b1}}) ? (share_q + COUNT_BITS'(1)) : share_q;
          sh_we_b = 1'b1;
          sh_wd_b = nv;
          r_cnt   = nv;
        end
        rba_pkg::MODE_DEC: begin
          nv      = (share_q != '0) ? (share_q - COUNT_BITS'(1)) : '0;
          sh_we_b = 1'b1;
          sh_wd_b = nv;
          r_cnt   = (nv != '0) ? nv : COUNT_BITS'(1);
        end
        rba_pkg::MODE_QUERY: begin
          r_cnt = eff;
        end
        rba_pkg::MODE_COW: begin
          if (share_q > COUNT_BITS'(1)) begin
            if (found) begin
              nv      = share_q - COUNT_BITS'(1);
              sh_we_b = 1'b1;
              sh_wd_b = nv;
              r_cnt   = nv;
              r_bout  = got_w;
              bm_we   = 1'b1;
              bm_wa   = found_w;
              bm_wd   = found_data | (WB'(1) << found_b);
              new_we  = 1'b1;
              free_dn = 1'b1;
            end else begin
              r_bout = '0;
              r_st   = rba_pkg::STS_NO_FREE;
              r_cnt  = share_q;
            end
          end else begin
            r_cnt = eff;
          end
        end
        default: begin
          r_st = rba_pkg::STS_RANGE;
        end
      endcase
    end
    r_free = range_size - alloc_cnt + BW'(free_up) - BW'(free_dn);
  end

  // Bitmap memory port control: clearing pass, scan reads, one write-back.
  assign bm_rd   = (state == ST_SCAN) && (rd_word != (WIW + 1)'(NWORDS));
  assign bm_wr   = (state == ST_CLR) || ((state == ST_EXEC) && bm_we);
  assign bm_addr = (state == ST_CLR) ? rd_word[WIW-1:0] : bm_wa;
  assign bm_data = (state == ST_CLR) ? '0 : bm_wd;

  always_ff @(posedge clk) begin
    if (bm_wr) begin
      bm_mem[bm_addr] <= bm_data;
    end
    if (bm_rd) begin
      bm_q <= bm_mem[rd_word[WIW-1:0]];
    end
  end

  // Count memory: read at acceptance, written for the addressed and the new block.
  assign sh_wr   = ((state == ST_EXEC) && sh_we_b) || (state == ST_WNEW);
  assign sh_addr = (state == ST_WNEW) ? IDW'(got_w) : IDW'(b_w);
  assign sh_data = (state == ST_WNEW) ? COUNT_BITS'(1) : sh_wd_b;

  always_ff @(posedge clk) begin
    if (sh_wr) begin
      sh_mem[sh_addr] <= sh_data;
    end
    if (accept) begin
      share_q <= sh_mem[IDW'(block_id)];
    end
  end

  // Control sequencer, configuration registers and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLR;
      rd_word     <= '0;
      pv          <= 1'b0;
      found       <= 1'b0;
      rsp_valid   <= 1'b0;
      block_total <= rba_pkg::BLOCK_TOTAL_RST;
      data_start  <= rba_pkg::DATA_START_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        priority if (cfg_index == rba_pkg::CFG_BLOCK_TOTAL) begin
          block_total <= cfg_data;
        end else if (cfg_index == rba_pkg::CFG_DATA_START) begin
          data_start <= cfg_data;
        end
      end
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          rd_word <= rd_word + 1'b1;
          if (rd_word == (WIW + 1)'(NWORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rd_word <= '0;
            pv      <= 1'b0;
            found   <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (bm_rd) begin
            rd_word <= rd_word + 1'b1;
            pv      <= 1'b1;
          end else begin
            pv <= 1'b0;
          end
          if (pv && !found && (scan_free != '0)) begin
            found <= 1'b1;
          end
          if (pv && !bm_rd) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= new_we ? ST_WNEW : ST_DONE;
        end
        ST_WNEW: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item capture and scan accumulators.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q    <= mode;
      blk       <= block_id;
      alloc_cnt <= '0;
    end
    if (bm_rd) begin
      pw <= rd_word[WIW-1:0];
    end
    if ((state == ST_SCAN) && pv) begin
      alloc_cnt <= alloc_cnt + BW'(scan_pop);
      if (!found && (scan_free != '0)) begin
        found_w    <= pw;
        found_b    <= scan_low;
        found_data <= bm_q;
      end
      if (HW'(pw) == b_w[BW-1:WS]) begin
        tgt_data <= bm_q;
      end
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      block_out  <= rba_pkg::ID_W'(r_bout);
      ref_count  <= rba_pkg::CNT_OUT_W'(r_cnt);
      status     <= r_st;
      free_count <= rba_pkg::FREE_W'(r_free);
    end
  end

`ifndef SYNTHESIS
  // A block found by the scan lies inside the data range.
  a_found_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && found) |-> (got_w >= ds_w && got_w < lim_w))
    else $error("allocated block outside the data range");

  // Used blocks counted by the scan never exceed the size of the range.
  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> (alloc_cnt <= range_size))
    else $error("used block count exceeds the data range");

  // A response appears only after the done state.
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_DONE))
    else $error("response raised outside the done state");

  // The new-block count write follows an execute step that took a block.
  a_wnew_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WNEW) |-> ($past(state) == ST_EXEC && $past(new_we)))
    else $error("new block count written without a taken block");
`endif

endmodule
